// File: rtl/hse_pkg.sv
package hse_pkg;

  localparam int VALUE_W = 32;
  localparam int FUNC_W = 2;
  localparam int COUNT_W = 7;

  localparam int DEF_BUCKETS = 16;
  localparam int DEF_WAYS = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CONTAIN = 2'd0,
    FUNC_INSERT  = 2'd1,
    FUNC_REMOVE  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SUM,
    FR_REDUCE,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOKUP
  } back_state_t;

  typedef struct packed {
    logic               done;
    logic               answer;
    logic               bucket_full;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

// File: rtl/hse_ram.sv
module hse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/hse_fifo.sv
module hse_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hse_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] cnt;

  assign full = (cnt == FULL_CNT);
  assign empty = (cnt == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// File: rtl/hse_front.sv
module hse_front #(
  parameter int BUCKETS = hse_pkg::DEF_BUCKETS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [hse_pkg::FUNC_W-1:0] func,
  input  logic [hse_pkg::VALUE_W-1:0] value,
  output logic                       working,
  input  logic                       q_full,
  output logic                       push,
  output logic [hse_pkg::FUNC_W-1:0] q_func,
  output logic [hse_pkg::VALUE_W-1:0] q_value,
  output logic [$clog2(BUCKETS)-1:0] q_bucket
);

  import hse_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int GROUPS = 4;
  localparam int GROUP_BITS = VALUE_W / GROUPS;
  // A group sum stays below 8*BUCKETS and the total below 32*BUCKETS.
  localparam int PW = BW + 3;
  localparam int SW = BW + 5;
  localparam logic [SW-1:0] SUB1 = SW'(BUCKETS);
  localparam logic [SW-1:0] SUB2 = SW'(2 * BUCKETS);
  localparam logic [SW-1:0] SUB4 = SW'(4 * BUCKETS);
  localparam logic [SW-1:0] SUB8 = SW'(8 * BUCKETS);
  localparam logic [SW-1:0] SUB16 = SW'(16 * BUCKETS);

  typedef logic [VALUE_W-1:0][BW-1:0] weight_tab_t;

  // Weight of each value bit in the bucket: 2**i mod BUCKETS, and for the sign
  // bit the residue of -2**31, so the weighted sum gives the non-negative remainder.
  function automatic weight_tab_t calc_weights();
    weight_tab_t tab;
    logic [63:0] w;
    for (int i = 0; i < VALUE_W; i++) begin
      w = (64'd1 << i) % 64'(BUCKETS);
      if (i == VALUE_W - 1 && w != 64'd0) begin
        w = 64'(BUCKETS) - w;
      end
      tab[i] = BW'(w);
    end
    return tab;
  endfunction

  localparam weight_tab_t WEIGHTS = calc_weights();

  front_state_t state;
  front_state_t state_next;

  logic [FUNC_W-1:0]  func_r;
  logic [VALUE_W-1:0] value_r;
  logic [PW-1:0]      part [GROUPS];
  logic [PW-1:0]      part_next [GROUPS];
  logic [SW-1:0]      rem_hi;
  logic [SW-1:0]      rem_hi_next;
  logic [SW-1:0]      rem;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part_next[g] = '0;
      for (int j = 0; j < GROUP_BITS; j++) begin
        if (value_r[g*GROUP_BITS + j]) begin
          part_next[g] = part_next[g] + PW'(WEIGHTS[g*GROUP_BITS + j]);
        end
      end
    end
  end

  always_comb begin
    logic [SW-1:0] total;
    total = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + SW'(part[g]);
    end
    rem_hi_next = total;
    if (rem_hi_next >= SUB16) begin
      rem_hi_next = rem_hi_next - SUB16;
    end
    if (rem_hi_next >= SUB8) begin
      rem_hi_next = rem_hi_next - SUB8;
    end
  end

  always_comb begin
    rem = rem_hi;
    if (rem >= SUB4) begin
      rem = rem - SUB4;
    end
    if (rem >= SUB2) begin
      rem = rem - SUB2;
    end
    if (rem >= SUB1) begin
      rem = rem - SUB1;
    end
  end

  assign q_func = func_r;
  assign q_value = value_r;
  assign q_bucket = rem[BW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    push = 1'b0;
    working = 1'b1;
    case (state)
      FR_IDLE: begin
        working = 1'b0;
        if (accept) begin
          state_next = FR_SUM;
        end
      end
      FR_SUM: begin
        state_next = FR_REDUCE;
      end
      FR_REDUCE: begin
        state_next = FR_PUSH;
      end
      FR_PUSH: begin
        if (!q_full) begin
          push = 1'b1;
          state_next = FR_IDLE;
        end
      end
      default: begin
        state_next = FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == FR_IDLE && accept) begin
      func_r <= func;
      value_r <= value;
    end
    if (state == FR_SUM) begin
      for (int g = 0; g < GROUPS; g++) begin
        part[g] <= part_next[g];
      end
    end
    if (state == FR_REDUCE) begin
      rem_hi <= rem_hi_next;
    end
  end

endmodule

// File: rtl/hse_back.sv
module hse_back #(
  parameter int BUCKETS = hse_pkg::DEF_BUCKETS,
  parameter int WAYS = hse_pkg::DEF_WAYS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  logic [hse_pkg::FUNC_W-1:0] q_func,
  input  logic [hse_pkg::VALUE_W-1:0] q_value,
  input  logic [$clog2(BUCKETS)-1:0] q_bucket,
  output logic                       pop,
  output logic                       clearing,
  output hse_pkg::result_t           res
);

  import hse_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int RW = WAYS * (VALUE_W + 1);
  localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

  back_state_t state;
  back_state_t state_next;

  logic [BW-1:0]      clr_addr;
  logic [FUNC_W-1:0]  func_r;
  logic [VALUE_W-1:0] value_r;
  logic [BW-1:0]      bucket_r;
  logic [COUNT_W-1:0] count;

  logic               we;
  logic [BW-1:0]      waddr;
  logic [RW-1:0]      wdata;
  logic [RW-1:0]      rdata;

  logic [WAYS-1:0]    row_valid;
  logic [WAYS-1:0]    hit;
  logic [WAYS-1:0]    free;
  logic [WAYS-1:0]    first_free;
  logic [RW-1:0]      new_row;
  logic               row_write;
  logic               answer_next;
  logic               full_next;
  logic [COUNT_W-1:0] count_next;

  // A row holds the valid bits in its low end and then one value per way.
  hse_ram #(
    .WIDTH(RW),
    .DEPTH(BUCKETS)
  ) u_rows (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(q_bucket),
    .rdata(rdata)
  );

  assign row_valid = rdata[WAYS-1:0];
  assign free = ~row_valid;
  assign first_free = free & (~free + 1'b1);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = row_valid[w] && (rdata[WAYS + w*VALUE_W +: VALUE_W] == value_r);
    end
  end

  always_comb begin
    new_row = rdata;
    row_write = 1'b0;
    answer_next = 1'b0;
    full_next = 1'b0;
    count_next = count;
    case (func_t'(func_r))
      FUNC_CONTAIN: begin
        answer_next = |hit;
      end
      FUNC_INSERT: begin
        if (hit == '0) begin
          if (free == '0) begin
            full_next = 1'b1;
          end else begin
            row_write = 1'b1;
            answer_next = 1'b1;
            count_next = count + 1'b1;
            new_row[WAYS-1:0] = row_valid | first_free;
            for (int w = 0; w < WAYS; w++) begin
              if (first_free[w]) begin
                new_row[WAYS + w*VALUE_W +: VALUE_W] = value_r;
              end
            end
          end
        end
      end
      FUNC_REMOVE: begin
        if (hit != '0) begin
          row_write = 1'b1;
          answer_next = 1'b1;
          count_next = count - 1'b1;
          new_row[WAYS-1:0] = row_valid & ~hit;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    clearing = 1'b0;
    we = 1'b0;
    waddr = bucket_r;
    wdata = new_row;
    case (state)
      BK_CLEAR: begin
        clearing = 1'b1;
        we = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        if (clr_addr == LAST_ROW) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          state_next = BK_LOOKUP;
        end
      end
      BK_LOOKUP: begin
        we = row_write;
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      count <= '0;
      res.done <= 1'b0;
    end else begin
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == BK_LOOKUP) begin
        count <= count_next;
        res.answer <= answer_next;
        res.bucket_full <= full_next;
        res.count <= count_next;
      end
      res.done <= (state == BK_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      func_r <= q_func;
      value_r <= q_value;
      bucket_r <= q_bucket;
    end
  end

endmodule

// File: rtl/hash_set_engine_unit.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------------
// request  | start, busy (low=ready) | func, value
// result   | done (one-cycle strobe) | answer, bucket_full, element_count
//
// The front end folds per-bit residues of value into a bucket in its sum and
// reduce states and pushes it into the queue, busy high all the while; a new
// request is taken once the last is queued. The back end pops it, reads the
// bucket row and writes it back before the front end can push again, so the
// queue never fills. After reset the bucket rows are cleared one per cycle,
// with busy high. The receiver cannot stall: every result is shown for one cycle.
module hash_set_engine_unit #(
  parameter int BUCKETS = hse_pkg::DEF_BUCKETS,
  parameter int WAYS = hse_pkg::DEF_WAYS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [hse_pkg::FUNC_W-1:0]         func,
  input  logic signed [hse_pkg::VALUE_W-1:0] value,
  output logic                               done,
  output logic                               answer,
  output logic                               bucket_full,
  output logic [hse_pkg::COUNT_W-1:0]        element_count
);

  import hse_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int QW = FUNC_W + VALUE_W + BW;

  logic              accept;
  logic              front_working;
  logic              clearing;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  logic [FUNC_W-1:0] f_func;
  logic [VALUE_W-1:0] f_value;
  logic [BW-1:0]     f_bucket;
  logic [QW-1:0]     q_head;
  result_t           res;

  assign busy = front_working || clearing;
  assign accept = start && !busy;

  hse_front #(
    .BUCKETS(BUCKETS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .func    (func),
    .value   (value),
    .working (front_working),
    .q_full  (q_full),
    .push    (push),
    .q_func  (f_func),
    .q_value (f_value),
    .q_bucket(f_bucket)
  );

  hse_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data({f_func, f_value, f_bucket}),
    .pop    (pop),
    .rd_data(q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  hse_back #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_func  (q_head[QW-1 -: FUNC_W]),
    .q_value (q_head[BW +: VALUE_W]),
    .q_bucket(q_head[BW-1:0]),
    .pop     (pop),
    .clearing(clearing),
    .res     (res)
  );

  assign done = res.done;
  assign answer = res.answer;
  assign bucket_full = res.bucket_full;
  assign element_count = res.count;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hse_pkg::*;

  localparam int BUCKETS = DEF_BUCKETS;
  localparam int WAYS = DEF_WAYS;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  typedef struct {
    logic               answer;
    logic               bucket_full;
    logic [COUNT_W-1:0] count;
  } reply_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;
  logic                      done;
  logic                      answer;
  logic                      bucket_full;
  logic [COUNT_W-1:0]        element_count;

  // Shadow copy of the set contents.
  logic [VALUE_W-1:0] set_value [SLOTS];
  bit                 set_valid [SLOTS];
  logic [COUNT_W-1:0] set_count;

  reply_t pending_results[$];
  int     idle_pct;
  int     requests_sent;
  int     results_checked;
  int     refused_inserts;
  int     peak_count;
  int     mismatches;
  int     cycle_count;

  hash_set_engine_unit #(
    .BUCKETS(BUCKETS),
    .WAYS(WAYS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .value(value),
    .done(done),
    .answer(answer),
    .bucket_full(bucket_full),
    .element_count(element_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAIL hash_set_engine_unit");
      $finish;
    end
  end

  // Non-negative remainder of the signed key.
  function automatic int bucket_index(logic signed [VALUE_W-1:0] key);
    int r;
    r = int'(key) % BUCKETS;
    if (r < 0) r += BUCKETS;
    return r;
  endfunction

  function automatic reply_t apply_request(logic [FUNC_W-1:0] op,
                                           logic signed [VALUE_W-1:0] key);
    reply_t rep;
    int     base;
    int     hit;
    int     w;
    base = bucket_index(key) * WAYS;
    hit = -1;
    rep.answer = 1'b0;
    rep.bucket_full = 1'b0;
    for (w = 0; w < WAYS; w++) begin
      if (hit < 0 && set_valid[base + w] && set_value[base + w] == key) hit = w;
    end
    case (op)
      FUNC_CONTAIN: begin
        rep.answer = (hit >= 0);
      end
      FUNC_INSERT: begin
        if (hit < 0) begin
          rep.bucket_full = 1'b1;
          for (w = 0; w < WAYS; w++) begin
            if (!set_valid[base + w]) begin
              set_valid[base + w] = 1'b1;
              set_value[base + w] = key;
              set_count = set_count + 1'b1;
              rep.answer = 1'b1;
              rep.bucket_full = 1'b0;
              break;
            end
          end
        end
      end
      FUNC_REMOVE: begin
        if (hit >= 0) begin
          set_valid[base + hit] = 1'b0;
          set_count = set_count - 1'b1;
          rep.answer = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rep.count = set_count;
    return rep;
  endfunction

  always @(posedge clk) begin : check_result
    reply_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: answer=%0b full=%0b count=%0d", answer, bucket_full,
                   element_count);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (answer !== want.answer || bucket_full !== want.bucket_full ||
            element_count !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch on result %0d: expected answer=%0b full=%0b count=%0d, got answer=%0b full=%0b count=%0d",
                     results_checked, want.answer, want.bucket_full, want.count, answer,
                     bucket_full, element_count);
        end
      end
    end
  end

  // One request beat, held until the engine takes it, followed by an optional gap.
  task automatic send_request(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] key);
    reply_t rep;
    @(negedge clk);
    start = 1'b1;
    func = op;
    value = key;
    while (busy) @(negedge clk);
    @(posedge clk);
    rep = apply_request(op, key);
    pending_results.push_back(rep);
    requests_sent++;
    if (rep.bucket_full) refused_inserts++;
    if (int'(rep.count) > peak_count) peak_count = int'(rep.count);
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_key();
    int k;
    case ($urandom_range(0, 9))
      7: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      8, 9: return $urandom;
      default: begin
        // A small crowded pool: 36 keys of either sign over four buckets.
        k = (int'($urandom_range(0, 8)) - 4) * BUCKETS + int'($urandom_range(0, 3));
        return k;
      end
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return FUNC_INSERT;
    if (r < 65) return FUNC_CONTAIN;
    if (r < 95) return FUNC_REMOVE;
    return FUNC_NOP;
  endfunction

  task automatic test_directed();
    idle_pct = 33;
    send_request(FUNC_CONTAIN, 32'h0000_0000);
    send_request(FUNC_INSERT, 32'h0000_0000);
    send_request(FUNC_INSERT, 32'h0000_0000);
    send_request(FUNC_CONTAIN, 32'h0000_0000);
    send_request(FUNC_INSERT, 32'hFFFF_FFFF);
    send_request(FUNC_INSERT, 32'h7FFF_FFFF);
    send_request(FUNC_INSERT, 32'h8000_0000);
    send_request(FUNC_CONTAIN, 32'h8000_0000);
    send_request(FUNC_NOP, 32'h0000_0000);
    send_request(FUNC_INSERT, 32'd16);
    send_request(FUNC_INSERT, 32'd32);
    // Bucket zero now holds four keys, so the next insert is refused.
    send_request(FUNC_INSERT, 32'd48);
    send_request(FUNC_REMOVE, 32'd48);
    send_request(FUNC_REMOVE, 32'd16);
    send_request(FUNC_INSERT, 32'd48);
    send_request(FUNC_CONTAIN, 32'd48);
    send_request(FUNC_REMOVE, 32'hFFFF_FFFF);
    send_request(FUNC_REMOVE, 32'hFFFF_FFFF);
    send_request(FUNC_CONTAIN, 32'h7FFF_FFFF);
    send_request(FUNC_CONTAIN, 32'hFFFF_FFF0);
    send_request(FUNC_NOP, 32'hFFFF_FFFF);
    send_request(FUNC_REMOVE, 32'h8000_0000);
  endtask

  // Fill every slot of the table, try one more key, then empty it again.
  task automatic test_fill_and_drain();
    logic [VALUE_W-1:0] keys [SLOTS];
    int                 b;
    int                 w;
    int                 i;
    idle_pct = 47;
    for (i = 0; i < SLOTS; i++)
      if (set_valid[i]) send_request(FUNC_REMOVE, set_value[i]);
    for (b = 0; b < BUCKETS; b++) begin
      for (w = 0; w < WAYS; w++) begin
        keys[b * WAYS + w] = $urandom * SLOTS + w * BUCKETS + b;
        send_request(FUNC_INSERT, keys[b * WAYS + w]);
      end
    end
    send_request(FUNC_INSERT, $urandom * SLOTS + BUCKETS + 5);
    send_request(FUNC_CONTAIN, keys[$urandom_range(0, SLOTS - 1)]);
    for (i = 0; i < SLOTS; i++) begin
      send_request(FUNC_REMOVE, keys[i]);
      if (i % 16 == 0) send_request(FUNC_CONTAIN, keys[i]);
    end
  endtask

  task automatic test_random(input int n_items, input int gap_pct);
    int i;
    idle_pct = gap_pct;
    for (i = 0; i < n_items; i++) send_request(pick_op(), pick_key());
  endtask

  task automatic finish_run();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d contain, insert, remove and idle-code requests; %0d results compared.",
             requests_sent, results_checked);
    $display("Table filled to %0d values, %0d inserts refused, %0d mismatches.", peak_count,
             refused_inserts, mismatches);
    if (mismatches == 0)
      $display("PASS hash_set_engine_unit");
    else
      $display("FAIL hash_set_engine_unit");
    $finish;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_CONTAIN;
    value = '0;
    idle_pct = 0;
    requests_sent = 0;
    results_checked = 0;
    refused_inserts = 0;
    peak_count = 0;
    mismatches = 0;
    cycle_count = 0;
    set_count = '0;
    for (int i = 0; i < SLOTS; i++) set_valid[i] = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_fill_and_drain();
    test_random(85, 33);
    test_random(85, 47);
    test_random(85, 0);
    finish_run();
  end

endmodule

// File: files.f
rtl/hse_pkg.sv
rtl/hse_ram.sv
rtl/hse_fifo.sv
rtl/hse_front.sv
rtl/hse_back.sv
rtl/hash_set_engine_unit.sv
dv/testbench.sv
